>>> design/mtf_pkg.sv
package mtf_pkg;

	// default list length
	localparam int MAX_ALPHABET_DEF = 256;

	// fixed field widths
	localparam int SYM_W  = 8;
	localparam int CFG_W  = 9;
	localparam int CIDX_W = 1;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_DECODE_MODE   = 1'd0;
	localparam logic [CIDX_W-1:0] CFG_ALPHABET_SIZE = 1'd1;

	// what travels from one cell to the next along with the item
	typedef struct packed {
		logic             found;   // hit already seen, later cells only pass along
		logic             oor;     // value was out of range, list not reordered
		logic             decode;  // mode captured at accept
		logic [SYM_W-1:0] value;   // symbol or position being looked for
		logic [SYM_W-1:0] carry;   // old symbol of the previous cell
		logic [SYM_W-1:0] front;   // symbol that goes to the front
		logic [SYM_W-1:0] pos;     // position of the hit
	} mtf_link_t;

endpackage

>>> design/mtf_cell.sv
module mtf_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_identity,
	input  logic              front_we,
	input  logic [7:0]        front_sym,
	input  logic              valid_in,
	input  mtf_pkg::mtf_link_t link_in,
	output logic              valid_out,
	output mtf_pkg::mtf_link_t link_out
);
	import mtf_pkg::*;

	localparam logic [SYM_W-1:0] MyIdx = SYM_W'(IDX);

	logic [SYM_W-1:0] sym_q;
	logic             valid_q;
	mtf_link_t        link_q;
	mtf_link_t        link_d;
	logic             act;
	logic             match;

	// a cell acts while the item passes and no hit was seen in front of it
	assign act   = valid_in && !link_in.found;
	assign match = link_in.decode ? (link_in.value == MyIdx) : (sym_q == link_in.value);

	// outgoing link: hand own old symbol back, record the hit here
	always_comb begin
		link_d       = link_in;
		link_d.carry = sym_q;
		if (act && match) begin
			link_d.found = 1'b1;
			link_d.front = sym_q;
			link_d.pos   = MyIdx;
		end
	end

	// stored symbol: identity at reset or load, front write, or shift back by one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= MyIdx;
		end else if (load_identity) begin
			sym_q <= MyIdx;
		end else if (front_we) begin
			sym_q <= front_sym;
		end else if (act && (IDX != 0)) begin
			sym_q <= link_in.carry;
		end
	end

	// link register to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		link_q <= link_d;
	end

	assign valid_out = valid_q;
	assign link_out  = link_q;

endmodule

>>> design/move_to_front_codec.sv
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------
// input    | in_valid / in_stall  | value_in, start_of_message
// output   | out_valid / out_stall| value_out, out_of_range
// config   | cfg_we               | cfg_index, cfg_wdata
//
// An item is accepted only after the previous result has left the result stage:
// it passes the launch register, walks the row of list cells one cell per cycle,
// then the result stage and the output register follow.
// After reset the list is in identity order and the block is ready at once.
// A result waiting under out_stall is held in the output register; the next
// item is still accepted, its result waits in the result stage.
module move_to_front_codec #(
	parameter int MAX_ALPHABET = mtf_pkg::MAX_ALPHABET_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [mtf_pkg::CIDX_W-1:0] cfg_index,
	input  logic [mtf_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                value_in,
	input  logic                      start_of_message,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                value_out,
	output logic                      out_of_range
);
	import mtf_pkg::*;

	localparam logic [CFG_W-1:0] MaxLim = CFG_W'(MAX_ALPHABET);

	logic             decode_mode_q;
	logic [CFG_W-1:0] alphabet_size_q;
	logic             busy_q;
	logic             launch_valid_q;
	mtf_link_t        launch_q;
	logic             done_valid_q;
	logic [SYM_W-1:0] done_value_q;
	logic             done_oor_q;
	logic             out_valid_q;
	logic [SYM_W-1:0] value_out_q;
	logic             oor_q;

	logic             in_acc;
	logic             done_move;
	logic [CFG_W-1:0] limit;
	logic             oor_in;
	logic             end_valid;
	mtf_link_t        end_link;
	logic             front_we;

	logic             link_valid [0:MAX_ALPHABET];
	mtf_link_t        link       [0:MAX_ALPHABET];

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = busy_q;
	assign done_move = done_valid_q && (!out_valid_q || !out_stall);

	// usable size and range check
	assign limit  = (alphabet_size_q > MaxLim) ? MaxLim : alphabet_size_q;
	assign oor_in = {1'b0, value_in} >= limit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q   <= 1'b0;
			alphabet_size_q <= CFG_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DECODE_MODE:   decode_mode_q   <= cfg_wdata[0];
				CFG_ALPHABET_SIZE: alphabet_size_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// control: busy from accept until the result leaves the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			launch_valid_q <= 1'b0;
			done_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			launch_valid_q <= in_acc;
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (done_move) begin
				busy_q <= 1'b0;
			end
			if (end_valid) begin
				done_valid_q <= 1'b1;
			end else if (done_move) begin
				done_valid_q <= 1'b0;
			end
			if (done_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// launch register: the list gets its identity load at the accept edge first
	always_ff @(posedge clk) begin
		if (in_acc) begin
			launch_q.found  <= oor_in;
			launch_q.oor    <= oor_in;
			launch_q.decode <= decode_mode_q;
			launch_q.value  <= value_in;
			launch_q.carry  <= '0;
			launch_q.front  <= '0;
			launch_q.pos    <= '0;
		end
	end

	assign link_valid[0] = launch_valid_q;
	assign link[0]       = launch_q;

	// row of list cells, entry k of the list in cell k
	for (genvar k = 0; k < MAX_ALPHABET; k++) begin : g_cell
		mtf_cell #(
			.IDX(k)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.load_identity(in_acc && start_of_message),
			.front_we     ((k == 0) ? front_we : 1'b0),
			.front_sym    (end_link.front),
			.valid_in     (link_valid[k]),
			.link_in      (link[k]),
			.valid_out    (link_valid[k+1]),
			.link_out     (link[k+1])
		);
	end

	// end of the row: hit symbol goes to the front
	assign end_valid = link_valid[MAX_ALPHABET];
	assign end_link  = link[MAX_ALPHABET];
	assign front_we  = end_valid && !end_link.oor;

	// result stage
	always_ff @(posedge clk) begin
		if (end_valid) begin
			done_oor_q <= end_link.oor;
			if (end_link.oor) begin
				done_value_q <= '0;
			end else if (end_link.decode) begin
				done_value_q <= end_link.front;
			end else begin
				done_value_q <= end_link.pos;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (done_move) begin
			value_out_q <= done_value_q;
			oor_q       <= done_oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign value_out    = value_out_q;
	assign out_of_range = oor_q;

endmodule

>>> tb/sv/move_to_front_codec_tb.sv
`timescale 1ns / 100ps

module move_to_front_codec_tb;

	localparam int LIST_LEN = mtf_pkg::MAX_ALPHABET_DEF;
	localparam int ITEM_CYCLES = LIST_LEN + 3;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 150;
	localparam int MAX_REPORTS = 50;

	// mode codes of the decode_mode register
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic [7:0] value;
		logic       oor;
	} mtf_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [mtf_pkg::CIDX_W-1:0] cfg_index;
	logic [mtf_pkg::CFG_W-1:0]  cfg_wdata;
	logic                       in_valid;
	logic                       in_stall;
	logic [7:0]                 value_in;
	logic                       start_of_message;
	logic                       out_valid;
	logic                       out_stall;
	logic [7:0]                 value_out;
	logic                       out_of_range;

	// predictor state: list order and register copies
	logic [7:0]  rank_list [LIST_LEN];
	logic        cur_mode;
	logic [8:0]  cur_size;

	mtf_result_t expected_codes [$];

	bit          calm;
	int unsigned long_hold;
	int unsigned items_sent;
	int unsigned results_checked;
	int unsigned oor_items;
	int unsigned message_starts;
	int unsigned settings_used;
	int unsigned fail_count;

	move_to_front_codec dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.value_in         (value_in),
		.start_of_message (start_of_message),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.value_out        (value_out),
		.out_of_range     (out_of_range)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// list back to identity order
	function automatic void list_restart();
		for (int i = 0; i < LIST_LEN; i++)
			rank_list[i] = 8'(i);
	endfunction

	// expected result of one item, list updated as the block does
	function automatic mtf_result_t mtf_predict(input logic [7:0] v, input logic som);
		mtf_result_t res;
		int unsigned limit;
		int unsigned pos;
		logic [7:0] sym;
		limit = (cur_size > LIST_LEN) ? LIST_LEN : cur_size;
		if (som)
			list_restart();
		res.value = 8'd0;
		res.oor = 1'b0;
		if (v >= limit) begin
			res.oor = 1'b1;
			return res;
		end
		pos = 0;
		if (cur_mode == MODE_DECODE) begin
			pos = v;
			res.value = rank_list[pos];
		end else begin
			for (int p = LIST_LEN - 1; p >= 0; p--)
				if (rank_list[p] == v)
					pos = p;
			res.value = 8'(pos);
		end
		// symbol to the front, entries ahead of it move back
		sym = rank_list[pos];
		for (int i = pos; i > 0; i--)
			rank_list[i] = rank_list[i - 1];
		rank_list[0] = sym;
		return res;
	endfunction

	function automatic int unsigned idle_draw();
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	// offer one item, record its expectation once taken
	task automatic send_item(input logic [7:0] v, input logic som);
		int unsigned gap;
		gap = idle_draw();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value_in <= v;
		start_of_message <= som;
		do @(posedge clk); while (in_stall);
		expected_codes.push_back(mtf_predict(v, som));
		items_sent++;
		if (som)
			message_starts++;
		if (expected_codes[$].oor)
			oor_items++;
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_codes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mtf_pkg::CIDX_W-1:0] idx,
			input logic [mtf_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// new setting, written only with the block idle
	task automatic configure(input logic mode, input logic [8:0] size);
		drain();
		write_reg(mtf_pkg::CFG_DECODE_MODE, {8'd0, mode});
		write_reg(mtf_pkg::CFG_ALPHABET_SIZE, size);
		cur_mode = mode;
		cur_size = size;
		settings_used++;
	endtask

	task automatic test_encode_basics();
		configure(MODE_ENCODE, 9'd256);
		send_item(8'd0, 1'b1);
		send_item(8'd255, 1'b0);
		send_item(8'd255, 1'b0);
		send_item(8'd0, 1'b0);
		send_item(8'd128, 1'b0);
		send_item(8'd7, 1'b1);
	endtask

	task automatic test_decode_basics();
		configure(MODE_DECODE, 9'd256);
		send_item(8'd255, 1'b1);
		send_item(8'd0, 1'b0);
		send_item(8'd1, 1'b0);
		send_item(8'd200, 1'b0);
	endtask

	// smallest alphabet; message start still applies on a flagged item
	task automatic test_out_of_range();
		configure(MODE_ENCODE, 9'd1);
		send_item(8'd0, 1'b1);
		send_item(8'd1, 1'b0);
		send_item(8'd255, 1'b1);
		configure(MODE_DECODE, 9'd1);
		send_item(8'd0, 1'b0);
		send_item(8'd128, 1'b0);
	endtask

	// shrink the alphabet mid-message so ranks and symbols pass the size
	task automatic test_size_change();
		configure(MODE_ENCODE, 9'd256);
		send_item(8'd200, 1'b1);
		send_item(8'd201, 1'b0);
		send_item(8'd202, 1'b0);
		send_item(8'd203, 1'b0);
		configure(MODE_ENCODE, 9'd4);
		send_item(8'd3, 1'b0);
		configure(MODE_DECODE, 9'd4);
		send_item(8'd1, 1'b0);
		configure(MODE_DECODE, 9'd255);
		send_item(8'd255, 1'b0);
	endtask

	// both modes share one list
	task automatic test_mode_change();
		configure(MODE_ENCODE, 9'd256);
		send_item(8'd10, 1'b1);
		send_item(8'd20, 1'b0);
		configure(MODE_DECODE, 9'd256);
		send_item(8'd1, 1'b0);
	endtask

	// mostly in-range symbols with a bias to small ones, some flagged ones when the alphabet is short
	function automatic logic [7:0] draw_value(input int unsigned limit);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10 && limit < LIST_LEN)
			return 8'($urandom_range(limit, 255));
		if (r < 40)
			return 8'($urandom_range(0, ((limit < 8) ? limit : 8) - 1));
		return 8'($urandom_range(0, limit - 1));
	endfunction

	task automatic test_random();
		logic        mode;
		logic [8:0]  size;
		logic        som;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin mode = MODE_ENCODE; size = 9'd256; end
				1: begin mode = MODE_DECODE; size = 9'd1; end
				2: begin mode = MODE_DECODE; size = 9'd256; end
				3: begin mode = MODE_ENCODE; size = 9'd1; end
				4: begin mode = MODE_ENCODE; size = 9'd2; end
				5: begin mode = MODE_DECODE; size = 9'd255; end
				default: begin
					mode = 1'($urandom_range(0, 1));
					case ($urandom_range(0, 3))
						0: size = 9'd256;
						1: size = 9'($urandom_range(1, 8));
						default: size = 9'($urandom_range(1, 256));
					endcase
				end
			endcase
			configure(mode, size);
			calm = (ph % 4 == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == 0)
					som = 1'($urandom_range(0, 1));
				else
					som = ($urandom_range(0, 39) == 0);
				send_item(draw_value(size), som);
			end
			calm = 1'b0;
		end
	endtask

	// receiver holds off long while the sender keeps offering
	task automatic test_backpressure();
		configure(MODE_ENCODE, 9'd256);
		long_hold = 4 * ITEM_CYCLES + 500;
		calm = 1'b1;
		for (int i = 0; i < 12; i++)
			send_item(8'($urandom_range(0, 255)), i == 0);
		calm = 1'b0;
	endtask

	// receiver stall, placed over the result it waits for
	initial begin
		int unsigned n;
		int unsigned seen;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (long_hold != 0) begin
				out_stall <= 1'b1;
				repeat (long_hold) @(posedge clk);
				long_hold = 0;
				out_stall <= 1'b0;
			end else begin
				n = idle_draw();
				if (n != 0) begin
					out_stall <= 1'b1;
					seen = 0;
					while (seen < n) begin
						@(posedge clk);
						if (out_valid)
							seen++;
					end
					out_stall <= 1'b0;
				end
			end
			do @(posedge clk); while (!(out_valid && !out_stall) && long_hold == 0);
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		mtf_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_codes.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: unexpected item, expected none actual value_out %0d oor %0b",
						$time, value_out, out_of_range);
			end else begin
				exp_res = expected_codes.pop_front();
				results_checked++;
				if (value_out !== exp_res.value) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: value_out expected %0d actual %0d",
							$time, exp_res.value, value_out);
				end
				if (out_of_range !== exp_res.oor) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: out_of_range expected %0b actual %0b",
							$time, exp_res.oor, out_of_range);
				end
			end
		end
	end

	// test sequence
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		value_in <= 8'd0;
		start_of_message <= 1'b0;
		out_stall <= 1'b0;
		calm = 1'b0;
		long_hold = 0;
		list_restart();
		cur_mode = MODE_ENCODE;
		cur_size = 9'd256;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_encode_basics();
		test_decode_basics();
		test_out_of_range();
		test_size_change();
		test_mode_change();
		test_backpressure();
		test_random();

		drain();
		repeat (ITEM_CYCLES + 16) @(posedge clk);

		$display("covered %0d items over %0d settings of mode and size, %0d flagged, %0d message starts",
			items_sent, settings_used, oor_items, message_starts);
		$display("checked %0d results, %0d mismatches", results_checked, fail_count);
		if (fail_count == 0 && expected_codes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
